// ----- hw/rtl/ttrg_pkg.sv -----
// shared types, constants and font rom for the text to rectangle generator
package ttrg_pkg;

    localparam int COORD_BITS = 16;
    localparam int WIDE_BITS  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

    typedef logic signed [WIDE_BITS-1:0] wide_t;

    localparam wide_t COORD_HI = wide_t'((longint'(1) << (COORD_BITS - 1)) - longint'(1));
    localparam wide_t COORD_LO = -COORD_HI - wide_t'(1);

    // register map, word index
    localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] REG_PIXEL_SCALE = 2'd2;
    localparam logic [1:0] REG_DRAW_COLOR  = 2'd3;

    // '?' drawn for bad or unfinished sequences
    localparam logic [10:0] CP_FALLBACK = 11'h03F;

    typedef struct packed {
        logic [14:0] origin_x;
        logic [14:0] origin_y;
        logic [7:0]  scale;
        logic [15:0] color;
    } cfg_t;

    typedef struct packed {
        logic        wr;
        logic [14:0] value;
    } origin_wr_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic pen_step;
        logic second;
        logic restore;
    } cmd_t;

    typedef struct packed {
        logic rows_empty;
        logic adv0;
        logic adv1;
        logic eot;
        logic out_free;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GLYPH_A,
        ST_GLYPH_B
    } state_t;

    function automatic wide_t clamp_coord(input wide_t v);
        wide_t r;
        if (v > COORD_HI) begin
            r = COORD_HI;
        end else if (v < COORD_LO) begin
            r = COORD_LO;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [14:0] rows5(input logic [2:0] a, input logic [2:0] b,
                                          input logic [2:0] c, input logic [2:0] d,
                                          input logic [2:0] e);
        return {a, b, c, d, e};
    endfunction

    // top row in the high bits, leftmost pixel is the msb of each row
    function automatic logic [14:0] font_lookup(input logic [10:0] cp);
        logic [14:0] r;
        r = '0;
        case (cp)
            11'h030: r = rows5(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
            11'h031: r = rows5(3'd2, 3'd6, 3'd2, 3'd2, 3'd7);
            11'h032: r = rows5(3'd6, 3'd1, 3'd7, 3'd4, 3'd7);
            11'h033: r = rows5(3'd6, 3'd1, 3'd3, 3'd1, 3'd6);
            11'h034: r = rows5(3'd5, 3'd5, 3'd7, 3'd1, 3'd1);
            11'h035: r = rows5(3'd7, 3'd4, 3'd6, 3'd1, 3'd6);
            11'h036: r = rows5(3'd3, 3'd4, 3'd7, 3'd5, 3'd7);
            11'h037: r = rows5(3'd7, 3'd1, 3'd2, 3'd2, 3'd2);
            11'h038: r = rows5(3'd7, 3'd5, 3'd7, 3'd5, 3'd7);
            11'h039: r = rows5(3'd7, 3'd5, 3'd7, 3'd1, 3'd6);
            11'h041: r = rows5(3'd2, 3'd5, 3'd7, 3'd5, 3'd5);
            11'h042: r = rows5(3'd6, 3'd5, 3'd6, 3'd5, 3'd6);
            11'h043: r = rows5(3'd3, 3'd4, 3'd4, 3'd4, 3'd3);
            11'h044: r = rows5(3'd6, 3'd5, 3'd5, 3'd5, 3'd6);
            11'h045: r = rows5(3'd7, 3'd4, 3'd6, 3'd4, 3'd7);
            11'h046: r = rows5(3'd7, 3'd4, 3'd6, 3'd4, 3'd4);
            11'h047: r = rows5(3'd3, 3'd4, 3'd5, 3'd5, 3'd3);
            11'h048: r = rows5(3'd5, 3'd5, 3'd7, 3'd5, 3'd5);
            11'h049: r = rows5(3'd7, 3'd2, 3'd2, 3'd2, 3'd7);
            11'h04A: r = rows5(3'd1, 3'd1, 3'd1, 3'd5, 3'd2);
            11'h04B: r = rows5(3'd5, 3'd5, 3'd6, 3'd5, 3'd5);
            11'h04C: r = rows5(3'd4, 3'd4, 3'd4, 3'd4, 3'd7);
            11'h04D: r = rows5(3'd5, 3'd7, 3'd7, 3'd5, 3'd5);
            11'h04E: r = rows5(3'd5, 3'd7, 3'd7, 3'd7, 3'd5);
            11'h04F: r = rows5(3'd2, 3'd5, 3'd5, 3'd5, 3'd2);
            11'h050: r = rows5(3'd6, 3'd5, 3'd6, 3'd4, 3'd4);
            11'h051: r = rows5(3'd2, 3'd5, 3'd5, 3'd3, 3'd1);
            11'h052: r = rows5(3'd6, 3'd5, 3'd6, 3'd5, 3'd5);
            11'h053: r = rows5(3'd3, 3'd4, 3'd2, 3'd1, 3'd6);
            11'h054: r = rows5(3'd7, 3'd2, 3'd2, 3'd2, 3'd2);
            11'h055: r = rows5(3'd5, 3'd5, 3'd5, 3'd5, 3'd7);
            11'h056: r = rows5(3'd5, 3'd5, 3'd5, 3'd5, 3'd2);
            11'h057: r = rows5(3'd5, 3'd5, 3'd7, 3'd7, 3'd5);
            11'h058: r = rows5(3'd5, 3'd5, 3'd2, 3'd5, 3'd5);
            11'h059: r = rows5(3'd5, 3'd5, 3'd2, 3'd2, 3'd2);
            11'h05A: r = rows5(3'd7, 3'd1, 3'd2, 3'd4, 3'd7);
            11'h061: r = rows5(3'd2, 3'd5, 3'd7, 3'd5, 3'd5);
            11'h062: r = rows5(3'd6, 3'd5, 3'd6, 3'd5, 3'd6);
            11'h072: r = rows5(3'd6, 3'd5, 3'd6, 3'd5, 3'd5);
            11'h02D: r = rows5(3'd0, 3'd0, 3'd7, 3'd0, 3'd0);
            11'h03A: r = rows5(3'd0, 3'd2, 3'd0, 3'd2, 3'd0);
            11'h02E: r = rows5(3'd0, 3'd0, 3'd0, 3'd0, 3'd2);
            11'h025: r = rows5(3'd5, 3'd1, 3'd2, 3'd4, 3'd5);
            11'h02F: r = rows5(3'd1, 3'd1, 3'd2, 3'd4, 3'd4);
            11'h02B: r = rows5(3'd0, 3'd2, 3'd7, 3'd2, 3'd0);
            11'h021: r = rows5(3'd2, 3'd2, 3'd2, 3'd0, 3'd2);
            11'h03F: r = rows5(3'd6, 3'd1, 3'd2, 3'd0, 3'd2);
            11'h03E: r = rows5(3'd4, 3'd2, 3'd1, 3'd2, 3'd4);
            11'h03C: r = rows5(3'd1, 3'd2, 3'd4, 3'd2, 3'd1);
            11'h401: r = rows5(3'd5, 3'd7, 3'd4, 3'd6, 3'd7);
            11'h410: r = rows5(3'd2, 3'd5, 3'd7, 3'd5, 3'd5);
            11'h411: r = rows5(3'd7, 3'd4, 3'd6, 3'd5, 3'd6);
            11'h412: r = rows5(3'd6, 3'd5, 3'd6, 3'd5, 3'd6);
            11'h413: r = rows5(3'd7, 3'd4, 3'd4, 3'd4, 3'd4);
            11'h414: r = rows5(3'd2, 3'd5, 3'd5, 3'd7, 3'd5);
            11'h415: r = rows5(3'd7, 3'd4, 3'd6, 3'd4, 3'd7);
            11'h416: r = rows5(3'd5, 3'd2, 3'd7, 3'd2, 3'd5);
            11'h417: r = rows5(3'd6, 3'd1, 3'd3, 3'd1, 3'd6);
            11'h418: r = rows5(3'd5, 3'd5, 3'd7, 3'd7, 3'd5);
            11'h419: r = rows5(3'd2, 3'd5, 3'd7, 3'd7, 3'd5);
            11'h41A: r = rows5(3'd5, 3'd5, 3'd6, 3'd5, 3'd5);
            11'h41B: r = rows5(3'd3, 3'd5, 3'd5, 3'd5, 3'd5);
            11'h41C: r = rows5(3'd5, 3'd7, 3'd7, 3'd5, 3'd5);
            11'h41D: r = rows5(3'd5, 3'd5, 3'd7, 3'd5, 3'd5);
            11'h41E: r = rows5(3'd2, 3'd5, 3'd5, 3'd5, 3'd2);
            11'h41F: r = rows5(3'd7, 3'd5, 3'd5, 3'd5, 3'd5);
            11'h420: r = rows5(3'd6, 3'd5, 3'd6, 3'd4, 3'd4);
            11'h421: r = rows5(3'd3, 3'd4, 3'd4, 3'd4, 3'd3);
            11'h422: r = rows5(3'd7, 3'd2, 3'd2, 3'd2, 3'd2);
            11'h423: r = rows5(3'd5, 3'd5, 3'd3, 3'd1, 3'd6);
            11'h424: r = rows5(3'd2, 3'd7, 3'd2, 3'd7, 3'd2);
            11'h425: r = rows5(3'd5, 3'd5, 3'd2, 3'd5, 3'd5);
            11'h426: r = rows5(3'd5, 3'd5, 3'd5, 3'd7, 3'd1);
            11'h427: r = rows5(3'd5, 3'd5, 3'd3, 3'd1, 3'd1);
            11'h428: r = rows5(3'd5, 3'd5, 3'd5, 3'd5, 3'd7);
            11'h429: r = rows5(3'd5, 3'd5, 3'd5, 3'd7, 3'd1);
            11'h42A: r = rows5(3'd4, 3'd4, 3'd6, 3'd5, 3'd6);
            11'h42B: r = rows5(3'd5, 3'd5, 3'd7, 3'd5, 3'd7);
            11'h42C: r = rows5(3'd4, 3'd4, 3'd6, 3'd5, 3'd6);
            11'h42D: r = rows5(3'd6, 3'd1, 3'd3, 3'd1, 3'd6);
            11'h42E: r = rows5(3'd5, 3'd7, 3'd7, 3'd7, 3'd5);
            11'h42F: r = rows5(3'd3, 3'd5, 3'd3, 3'd5, 3'd5);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/text_to_rectangle_generator.sv -----
// top level of the text to rectangle generator: 3x5 font, utf-8 in, rectangles out
//
//   channel   dir   beat contents
//   --------  ----  ------------------------------------------------------------
//   s_axis    in    one text byte, tlast on the last byte of the string
//   m_axis    out   one filled rectangle, tlast on the last one caused by a byte
//   apb       in    origin_x, origin_y, pixel_scale, draw_color at 0x0/0x4/0x8/0xC
//
// the sequencer stays busy with a byte until it has emitted its rectangles, plus a
// '?' ahead of them when an orphaned lead byte adds one; the rectangle emitter gives
// one run of one glyph row per cycle unless m_axis stalls; a glyph gives at most 9 runs
// reset clears the sequencer, the pending lead, the pen and the output register;
// registers come up as origin 0, scale 1, color 0xffff
// a stalled m_axis holds the emitter, while the final rectangle of a byte waits
// in the output register the next byte can already be accepted
module text_to_rectangle_generator import ttrg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] text_byte
    input  logic        s_axis_tlast,    // end_of_text
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,    // [15:0] rect_x, [31:16] rect_y,
                                         // [41:32] rect_width, [49:42] rect_height,
                                         // [65:50] rect_color, [71:66] zero
    output logic        m_axis_tlast,    // last_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;
    origin_wr_t origin_wr;
    cmd_t       cmd;
    status_t    status;

    // apb never waits
    assign pready = 1'b1;

    // register bank, also reloads the pen when origin_x is written
    ttrg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .cfg       (cfg),
        .origin_wr (origin_wr)
    );

    // sequencer: idle -> glyph a -> (glyph b) -> idle
    ttrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // decode, font lookup, run scan, coordinate math, output register
    ttrg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .origin_wr (origin_wr),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_axis_tdata),
        .in_eot    (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // a rectangle that is not the last of its byte means the sequencer is still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken while a byte still has rectangles to emit");

    // every emitted rectangle has a nonzero size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[41:32] != 10'd0) && (m_axis_tdata[49:42] != 8'd0)))
        else $error("empty rectangle emitted");

    // with scale zero a byte draws nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (cfg.scale == 8'd0) && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("rectangle emitted with scale zero");

endmodule

// ----- hw/rtl/ttrg_cfg.sv -----
// apb register bank for origin, scale and color
module ttrg_cfg import ttrg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg,
    output origin_wr_t  origin_wr
);

    logic [14:0] origin_x_reg;
    logic [14:0] origin_y_reg;
    logic [7:0]  scale_reg;
    logic [15:0] color_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= 8'd1;
            color_reg    <= 16'hFFFF;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_ORIGIN_X:    origin_x_reg <= pwdata[14:0];
                REG_ORIGIN_Y:    origin_y_reg <= pwdata[14:0];
                REG_PIXEL_SCALE: scale_reg    <= pwdata[7:0];
                REG_DRAW_COLOR:  color_reg    <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ORIGIN_X:    prdata = {17'b0, origin_x_reg};
            REG_ORIGIN_Y:    prdata = {17'b0, origin_y_reg};
            REG_PIXEL_SCALE: prdata = {24'b0, scale_reg};
            REG_DRAW_COLOR:  prdata = {16'b0, color_reg};
        endcase
    end

    assign cfg.origin_x    = origin_x_reg;
    assign cfg.origin_y    = origin_y_reg;
    assign cfg.scale       = scale_reg;
    assign cfg.color       = color_reg;
    // pen reload travels with the written value
    assign origin_wr.wr    = wr_en && (paddr[3:2] == REG_ORIGIN_X);
    assign origin_wr.value = pwdata[14:0];

endmodule

// ----- hw/rtl/ttrg_ctrl.sv -----
// sequencer: takes a byte, walks glyphs a, b one rectangle per cycle if output free
module ttrg_ctrl import ttrg_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GLYPH_A;
                end
            end
            ST_GLYPH_A:
            begin
                if (!status.rows_empty)
                begin
                    cmd.emit = status.out_free;
                end
                else
                begin
                    cmd.pen_step = status.adv0;
                    if (status.adv1)
                    begin
                        cmd.second = 1'b1;
                        state_next = ST_GLYPH_B;
                    end
                    else
                    begin
                        cmd.restore = status.eot;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_GLYPH_B:
            begin
                if (!status.rows_empty)
                begin
                    cmd.emit = status.out_free;
                end
                else
                begin
                    cmd.pen_step = 1'b1;
                    cmd.restore  = status.eot;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ttrg_datapath.sv -----
// utf-8 decode, glyph row scanner, coordinate math, pen and output register
module ttrg_datapath import ttrg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  origin_wr_t  origin_wr,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [7:0]  in_byte,
    input  logic        in_eot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [71:0] out_data,
    output logic        out_last
);

    logic                         pending_reg;
    logic [4:0]                   payload_reg;
    logic [14:0]                  rows_reg;
    logic [14:0]                  next_rows_reg;
    logic                         adv0_reg;
    logic                         adv1_reg;
    logic                         eot_reg;
    logic signed [COORD_BITS-1:0] pen_reg;
    logic                         out_valid_reg;
    logic [71:0]                  out_data_reg;
    logic                         out_last_reg;

    // byte decode
    logic        byte_ascii;
    logic        byte_lead;
    logic        byte_cont;
    logic        fresh_hold;
    logic [10:0] fresh_cp;
    logic        g0_draw;
    logic        g1_draw;
    logic [10:0] g0_cp;
    logic [10:0] g1_cp;
    logic        hold_new;
    logic        scale_on;

    assign byte_ascii = !in_byte[7];
    assign byte_lead  = (in_byte[7:5] == 3'b110);
    assign byte_cont  = (in_byte[7:6] == 2'b10);
    assign fresh_hold = byte_lead && !in_eot;
    assign fresh_cp   = byte_ascii ? {3'b000, in_byte} : CP_FALLBACK;
    assign scale_on   = (cfg.scale != 8'd0);

    always_comb
    begin
        g1_cp = fresh_cp;
        if (pending_reg && byte_cont)
        begin
            g0_draw  = 1'b1;
            g0_cp    = {payload_reg, in_byte[5:0]};
            g1_draw  = 1'b0;
            hold_new = 1'b0;
        end
        else if (pending_reg)
        begin
            // orphaned lead draws '?', then the byte is decoded on its own
            g0_draw  = 1'b1;
            g0_cp    = CP_FALLBACK;
            g1_draw  = !fresh_hold;
            hold_new = fresh_hold;
        end
        else
        begin
            g0_draw  = !fresh_hold;
            g0_cp    = fresh_cp;
            g1_draw  = 1'b0;
            hold_new = fresh_hold;
        end
    end

    // first run of the topmost non-empty row
    logic [2:0]  row_idx;
    logic [2:0]  row_pix;
    logic [1:0]  run_col;
    logic [1:0]  run_len;
    logic [2:0]  run_mask;
    logic [14:0] clear_mask;
    logic [14:0] rows_after;

    always_comb
    begin
        row_idx = 3'd0;
        row_pix = 3'b000;
        for (int r = 4; r >= 0; r--)
        begin
            if (rows_reg[14 - 3 * r -: 3] != 3'b000)
            begin
                row_idx = 3'(r);
                row_pix = rows_reg[14 - 3 * r -: 3];
            end
        end
    end

    always_comb
    begin
        case (row_pix) inside
            3'b111:
            begin
                run_col = 2'd0; run_len = 2'd3; run_mask = 3'b111;
            end
            3'b110:
            begin
                run_col = 2'd0; run_len = 2'd2; run_mask = 3'b110;
            end
            3'b100, 3'b101:
            begin
                run_col = 2'd0; run_len = 2'd1; run_mask = 3'b100;
            end
            3'b011:
            begin
                run_col = 2'd1; run_len = 2'd2; run_mask = 3'b011;
            end
            3'b010:
            begin
                run_col = 2'd1; run_len = 2'd1; run_mask = 3'b010;
            end
            3'b001:
            begin
                run_col = 2'd2; run_len = 2'd1; run_mask = 3'b001;
            end
            default:
            begin
                run_col = 2'd0; run_len = 2'd0; run_mask = 3'b000;
            end
        endcase
    end

    assign clear_mask = 15'(run_mask) << (4'd12 - 4'(row_idx) * 4'd3);
    assign rows_after = rows_reg & ~clear_mask;

    // coordinates
    logic [9:0]  scale_x1;
    logic [9:0]  scale_x2;
    logic [9:0]  start_off;
    logic [9:0]  rect_width;
    logic [10:0] y_off;
    wide_t       pen_w;
    wide_t       x_cl;
    wide_t       y_cl;
    wide_t       step_cl;
    wide_t       origin_cl;
    wide_t       load_cl;

    assign scale_x1 = {2'b00, cfg.scale};
    assign scale_x2 = {1'b0, cfg.scale, 1'b0};

    always_comb
    begin
        case (run_col)
            2'd1:    start_off = scale_x1;
            2'd2:    start_off = scale_x2;
            default: start_off = 10'd0;
        endcase
        case (run_len)
            2'd1:    rect_width = scale_x1;
            2'd2:    rect_width = scale_x2;
            2'd3:    rect_width = scale_x1 + scale_x2;
            default: rect_width = 10'd0;
        endcase
    end

    assign y_off     = 11'(row_idx) * 11'(cfg.scale);
    assign pen_w     = {{(WIDE_BITS - COORD_BITS){pen_reg[COORD_BITS-1]}}, pen_reg};
    assign x_cl      = clamp_coord(pen_w + wide_t'(start_off));
    assign y_cl      = clamp_coord({{(WIDE_BITS - 15){cfg.origin_y[14]}}, cfg.origin_y}
                                   + wide_t'(y_off));
    assign step_cl   = clamp_coord(pen_w + wide_t'({cfg.scale, 2'b00}));
    assign origin_cl = clamp_coord({{(WIDE_BITS - 15){cfg.origin_x[14]}}, cfg.origin_x});
    assign load_cl   = clamp_coord({{(WIDE_BITS - 15){origin_wr.value[14]}}, origin_wr.value});

    // decode and glyph state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            payload_reg   <= '0;
            rows_reg      <= '0;
            next_rows_reg <= '0;
            adv0_reg      <= 1'b0;
            adv1_reg      <= 1'b0;
            eot_reg       <= 1'b0;
        end
        else if (cmd.load)
        begin
            pending_reg   <= hold_new;
            payload_reg   <= hold_new ? in_byte[4:0] : 5'd0;
            rows_reg      <= (g0_draw && scale_on) ? font_lookup(g0_cp) : 15'd0;
            next_rows_reg <= (g1_draw && scale_on) ? font_lookup(g1_cp) : 15'd0;
            adv0_reg      <= g0_draw;
            adv1_reg      <= g1_draw;
            eot_reg       <= in_eot;
        end
        else if (cmd.second)
        begin
            rows_reg      <= next_rows_reg;
            next_rows_reg <= '0;
        end
        else if (cmd.emit)
        begin
            rows_reg <= rows_after;
        end
    end

    // pen: a register write wins, end of text beats the glyph advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg <= '0;
        end
        else if (origin_wr.wr)
        begin
            pen_reg <= load_cl[COORD_BITS-1:0];
        end
        else if (cmd.restore)
        begin
            pen_reg <= origin_cl[COORD_BITS-1:0];
        end
        else if (cmd.pen_step)
        begin
            pen_reg <= step_cl[COORD_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {6'b0, cfg.color, cfg.scale, rect_width, y_cl[15:0], x_cl[15:0]};
            out_last_reg <= (rows_after == 15'd0) && (next_rows_reg == 15'd0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    assign status.rows_empty = (rows_reg == 15'd0);
    assign status.adv0       = adv0_reg;
    assign status.adv1       = adv1_reg;
    assign status.eot        = eot_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

// ----- dv/ttrg_rect_checker.sv -----
// rectangle predictor and stream checker for the text to rectangle generator
module ttrg_rect_checker import ttrg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] text_byte
    input  logic        s_axis_tlast,    // end_of_text
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,    // [15:0] rect_x, [31:16] rect_y, [41:32] rect_width,
                                         // [49:42] rect_height, [65:50] rect_color
    input  logic        m_axis_tlast,    // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int unsigned mismatch_count,
    output int unsigned rects_pending,
    output int unsigned rects_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [9:0]  w;
        logic [7:0]  h;
        logic [15:0] color;
        logic        last;
    } rect_t;

    localparam longint PEN_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint PEN_MIN = -PEN_MAX - 1;

    // utf-8 tag bits
    localparam logic [2:0] LEAD_TAG = 3'b110;
    localparam logic [1:0] CONT_TAG = 2'b10;

    cfg_t        cfg;
    longint      pen;
    logic        lead_held;
    logic [4:0]  lead_bits;
    rect_t       rects_due[$];
    int unsigned fail_total;
    int unsigned seen_total;

    function automatic logic [14:0] px(input int a, input int b, input int c,
                                       input int d, input int e);
        return {a[2:0], b[2:0], c[2:0], d[2:0], e[2:0]};
    endfunction

    // five 3-pixel rows, top row in the high bits, msb is the left pixel
    function automatic logic [14:0] glyph_rows(input logic [10:0] cp);
        logic [14:0] r;
        r = '0;
        case (cp)
            11'h030: r = px(7, 5, 5, 5, 7);  11'h031: r = px(2, 6, 2, 2, 7);
            11'h032: r = px(6, 1, 7, 4, 7);  11'h033: r = px(6, 1, 3, 1, 6);
            11'h034: r = px(5, 5, 7, 1, 1);  11'h035: r = px(7, 4, 6, 1, 6);
            11'h036: r = px(3, 4, 7, 5, 7);  11'h037: r = px(7, 1, 2, 2, 2);
            11'h038: r = px(7, 5, 7, 5, 7);  11'h039: r = px(7, 5, 7, 1, 6);
            11'h041: r = px(2, 5, 7, 5, 5);  11'h042: r = px(6, 5, 6, 5, 6);
            11'h043: r = px(3, 4, 4, 4, 3);  11'h044: r = px(6, 5, 5, 5, 6);
            11'h045: r = px(7, 4, 6, 4, 7);  11'h046: r = px(7, 4, 6, 4, 4);
            11'h047: r = px(3, 4, 5, 5, 3);  11'h048: r = px(5, 5, 7, 5, 5);
            11'h049: r = px(7, 2, 2, 2, 7);  11'h04A: r = px(1, 1, 1, 5, 2);
            11'h04B: r = px(5, 5, 6, 5, 5);  11'h04C: r = px(4, 4, 4, 4, 7);
            11'h04D: r = px(5, 7, 7, 5, 5);  11'h04E: r = px(5, 7, 7, 7, 5);
            11'h04F: r = px(2, 5, 5, 5, 2);  11'h050: r = px(6, 5, 6, 4, 4);
            11'h051: r = px(2, 5, 5, 3, 1);  11'h052: r = px(6, 5, 6, 5, 5);
            11'h053: r = px(3, 4, 2, 1, 6);  11'h054: r = px(7, 2, 2, 2, 2);
            11'h055: r = px(5, 5, 5, 5, 7);  11'h056: r = px(5, 5, 5, 5, 2);
            11'h057: r = px(5, 5, 7, 7, 5);  11'h058: r = px(5, 5, 2, 5, 5);
            11'h059: r = px(5, 5, 2, 2, 2);  11'h05A: r = px(7, 1, 2, 4, 7);
            11'h061: r = px(2, 5, 7, 5, 5);  11'h062: r = px(6, 5, 6, 5, 6);
            11'h072: r = px(6, 5, 6, 5, 5);  11'h02D: r = px(0, 0, 7, 0, 0);
            11'h03A: r = px(0, 2, 0, 2, 0);  11'h02E: r = px(0, 0, 0, 0, 2);
            11'h025: r = px(5, 1, 2, 4, 5);  11'h02F: r = px(1, 1, 2, 4, 4);
            11'h02B: r = px(0, 2, 7, 2, 0);  11'h021: r = px(2, 2, 2, 0, 2);
            11'h03F: r = px(6, 1, 2, 0, 2);  11'h03E: r = px(4, 2, 1, 2, 4);
            11'h03C: r = px(1, 2, 4, 2, 1);
            11'h401: r = px(5, 7, 4, 6, 7);  11'h410: r = px(2, 5, 7, 5, 5);
            11'h411: r = px(7, 4, 6, 5, 6);  11'h412: r = px(6, 5, 6, 5, 6);
            11'h413: r = px(7, 4, 4, 4, 4);  11'h414: r = px(2, 5, 5, 7, 5);
            11'h415: r = px(7, 4, 6, 4, 7);  11'h416: r = px(5, 2, 7, 2, 5);
            11'h417: r = px(6, 1, 3, 1, 6);  11'h418: r = px(5, 5, 7, 7, 5);
            11'h419: r = px(2, 5, 7, 7, 5);  11'h41A: r = px(5, 5, 6, 5, 5);
            11'h41B: r = px(3, 5, 5, 5, 5);  11'h41C: r = px(5, 7, 7, 5, 5);
            11'h41D: r = px(5, 5, 7, 5, 5);  11'h41E: r = px(2, 5, 5, 5, 2);
            11'h41F: r = px(7, 5, 5, 5, 5);  11'h420: r = px(6, 5, 6, 4, 4);
            11'h421: r = px(3, 4, 4, 4, 3);  11'h422: r = px(7, 2, 2, 2, 2);
            11'h423: r = px(5, 5, 3, 1, 6);  11'h424: r = px(2, 7, 2, 7, 2);
            11'h425: r = px(5, 5, 2, 5, 5);  11'h426: r = px(5, 5, 5, 7, 1);
            11'h427: r = px(5, 5, 3, 1, 1);  11'h428: r = px(5, 5, 5, 5, 7);
            11'h429: r = px(5, 5, 5, 7, 1);  11'h42A: r = px(4, 4, 6, 5, 6);
            11'h42B: r = px(5, 5, 7, 5, 7);  11'h42C: r = px(4, 4, 6, 5, 6);
            11'h42D: r = px(6, 1, 3, 1, 6);  11'h42E: r = px(5, 7, 7, 7, 5);
            11'h42F: r = px(3, 5, 3, 5, 5);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic longint saturate(input longint v);
        return (v > PEN_MAX) ? PEN_MAX : ((v < PEN_MIN) ? PEN_MIN : v);
    endfunction

    // one rectangle per horizontal run of set pixels, then the pen steps right; nothing at scale zero
    function automatic void draw_glyph(input logic [10:0] cp);
        logic [14:0] bits;
        logic [2:0]  row_pix;
        longint      sc;
        int          row;
        int          col;
        int          start;
        rect_t       r;
        bits = glyph_rows(cp);
        sc = longint'(cfg.scale);
        if (sc == 0)
            return;
        for (row = 0; row < 5; row++)
        begin
            row_pix = bits[14 - 3 * row -: 3];
            col = 0;
            while (col < 3)
            begin
                while (col < 3 && !row_pix[2 - col])
                    col++;
                start = col;
                while (col < 3 && row_pix[2 - col])
                    col++;
                if (col > start)
                begin
                    r.x     = 16'(saturate(pen + longint'(start) * sc));
                    r.y     = 16'(saturate(longint'($signed(cfg.origin_y)) + longint'(row) * sc));
                    r.w     = 10'(longint'(col - start) * sc);
                    r.h     = cfg.scale;
                    r.color = cfg.color;
                    r.last  = 1'b0;
                    rects_due.push_back(r);
                end
            end
        end
        pen = saturate(pen + 4 * sc);
    endfunction

    function automatic void decode_fresh(input logic [7:0] b, input logic eot);
        if (!b[7])
            draw_glyph({3'b000, b});
        else if (b[7:5] == LEAD_TAG && !eot)
        begin
            lead_held = 1'b1;
            lead_bits = b[4:0];
        end
        else
            draw_glyph(CP_FALLBACK);
    endfunction

    function automatic void take_text_byte(input logic [7:0] b, input logic eot);
        int first;
        first = rects_due.size();
        if (lead_held)
        begin
            lead_held = 1'b0;
            if (b[7:6] == CONT_TAG)
                draw_glyph({lead_bits, b[5:0]});
            else
            begin
                draw_glyph(CP_FALLBACK);
                decode_fresh(b, eot);
            end
        end
        else
            decode_fresh(b, eot);
        if (eot)
        begin
            pen       = saturate(longint'($signed(cfg.origin_x)));
            lead_held = 1'b0;
            lead_bits = '0;
        end
        if (rects_due.size() > first)
            rects_due[rects_due.size() - 1].last = 1'b1;
    endfunction

    function automatic int field_differs(input string name, input longint want,
                                         input longint got);
        if (want == got)
            return 0;
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rect_t want;
        if (!rst_n)
        begin
            cfg.origin_x = '0;
            cfg.origin_y = '0;
            cfg.scale    = 8'd1;
            cfg.color    = 16'hFFFF;
            pen          = 0;
            lead_held    = 1'b0;
            lead_bits    = '0;
            fail_total   = 0;
            seen_total   = 0;
            rects_due.delete();
            mismatch_count <= 0;
            rects_pending  <= 0;
            rects_checked  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_total++;
                if (rects_due.size() == 0)
                begin
                    $error("rectangle beat with nothing expected: x %0d y %0d",
                           $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
                    fail_total++;
                end
                else
                begin
                    want = rects_due.pop_front();
                    fail_total += field_differs("rect_x", $signed(want.x),
                                                $signed(m_axis_tdata[15:0]));
                    fail_total += field_differs("rect_y", $signed(want.y),
                                                $signed(m_axis_tdata[31:16]));
                    fail_total += field_differs("rect_width", want.w, m_axis_tdata[41:32]);
                    fail_total += field_differs("rect_height", want.h, m_axis_tdata[49:42]);
                    fail_total += field_differs("rect_color", want.color, m_axis_tdata[65:50]);
                    fail_total += field_differs("last_of_run", want.last, m_axis_tlast);
                    fail_total += field_differs("tdata padding", 0, m_axis_tdata[71:66]);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ORIGIN_X:
                    begin
                        cfg.origin_x = pwdata[14:0];
                        pen = saturate(longint'($signed(pwdata[14:0])));
                    end
                    REG_ORIGIN_Y:    cfg.origin_y = pwdata[14:0];
                    REG_PIXEL_SCALE: cfg.scale    = pwdata[7:0];
                    REG_DRAW_COLOR:  cfg.color    = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_text_byte(s_axis_tdata, s_axis_tlast);
            mismatch_count <= fail_total;
            rects_pending  <= rects_due.size();
            rects_checked  <= seen_total;
        end
    end

endmodule

// ----- dv/tb_text_to_rectangle_generator.sv -----
// testbench top: text and register stimulus for the text to rectangle generator
module tb_text_to_rectangle_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import ttrg_pkg::*;

    // watchdog limit, far above any sane run
    localparam int CYCLE_LIMIT       = 500_000;
    // quiet time once nothing is expected, covers a lead byte still in decode
    localparam int SETTLE_CYCLES     = 24;
    localparam int BYTES_PER_SETTING = 66;
    localparam int SETTING_COUNT     = 6;

    // opening text, bit 8 is end_of_text
    localparam logic [8:0] OPENING_TEXT [26] = '{
        9'h030, 9'h041, 9'h055, 9'h03F,  // '0', 'A', 'U' with nine runs, '?'
        9'h000, 9'h07F,                  // zero byte and an ascii code with no glyph
        9'h0D0, 9'h090, 9'h0D0, 9'h081,  // two-byte cyrillic capitals
        9'h0C1, 9'h081,                  // overlong form of 'A'
        9'h0D0, 9'h055,                  // orphaned lead, then 'U' in the same beat
        9'h0D0, 9'h0D0, 9'h0AF,          // lead replaced by a new lead
        9'h080, 9'h0BF, 9'h0E0,          // lone continuations and a byte above the leads
        9'h1FF,                          // top byte closes the string
        9'h1C3,                          // lead as the last byte
        9'h0D1, 9'h1D1,                  // pending lead, then a lead marked last
        9'h0D0, 9'h19F                   // a glyph as the last byte
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] text_byte
    logic        s_axis_tlast;    // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;    // [15:0] rect_x, [31:16] rect_y, [41:32] rect_width,
                                  // [49:42] rect_height, [65:50] rect_color, [71:66] zero
    logic        m_axis_tlast;    // last_of_run
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatch_count;
    int unsigned rects_pending;
    int unsigned rects_checked;

    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned strings_sent = 0;
    int unsigned settings_applied = 0;
    int          burst_left = 0;

    // receiver stall pattern state
    int          stall_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;

    string glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabr-:.%/+!?><";

    always #10 clk = ~clk;

    text_to_rectangle_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    ttrg_rect_checker rect_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .rects_pending  (rects_pending),
        .rects_checked  (rects_checked)
    );

    // receiver: modes change now and then between always ready, short and long stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 150);
        end
        else
            mode_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ((stall_mode == 1 && $urandom_range(0, 3) == 0) ||
                 (stall_mode == 2 && $urandom_range(0, 1) == 0))
        begin
            stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d rectangles still expected",
                   cycle_count, rects_pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one text beat; bursts of back-to-back beats, random gaps between bursts.
    // valid only drops when a real gap follows, so it never falls and rises in one step
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        bytes_sent++;
    endtask

    // hold the sender until every rectangle has come out, then let decode settle
    task automatic wait_until_drawn();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rects_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // apb write: setup beat, then access beat until pready; the caller idles the bus
    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // unused upper bits carry junk, the block must mask them
    task automatic apply_setting(input logic [14:0] ox, input logic [14:0] oy,
                                 input logic [7:0] scale, input logic [15:0] color);
        logic [31:0] junk;
        junk = $urandom();
        reg_write(REG_ORIGIN_X, {junk[31:15], ox});
        reg_write(REG_ORIGIN_Y, {junk[16:0], oy});
        reg_write(REG_PIXEL_SCALE, {junk[31:8], scale});
        reg_write(REG_DRAW_COLOR, {junk[15:0], color});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_applied++;
    endtask

    // one string: mostly font glyphs and two-byte sequences, some noise;
    // every eighth string or so is left open and runs on into the next
    task automatic send_phrase(input int max_len);
        int          len;
        int          pick;
        int          i;
        logic        close;
        logic        tail;
        logic [10:0] cp;
        len   = $urandom_range(1, max_len);
        close = ($urandom_range(0, 7) != 0);
        for (i = 0; i < len; i++)
        begin
            tail = close && (i == len - 1);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_byte(glyph_chars[$urandom_range(0, glyph_chars.len() - 1)], tail);
            else if (pick < 75)
            begin
                // cyrillic block mostly, any two-byte code point incl. overlong otherwise
                if (pick < 68)
                    cp = 11'h400 + 11'($urandom_range(0, 8'h4F));
                else
                    cp = 11'($urandom_range(0, 11'h7FF));
                send_byte({3'b110, cp[10:6]}, 1'b0);
                send_byte({2'b10, cp[5:0]}, tail);
            end
            else if (pick < 85)
                send_byte(8'($urandom_range(1, 127)), tail);
            else
                send_byte(8'($urandom_range(1, 255)), tail);
        end
        strings_sent++;
    endtask

    initial
    begin
        int          setting;
        int          max_len;
        int unsigned stop_at;
        logic [7:0]  scale;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text at the reset settings: origin 0, scale 1, color all ones
        foreach (OPENING_TEXT[k])
            send_byte(OPENING_TEXT[k][7:0], OPENING_TEXT[k][8]);
        wait_until_drawn();

        // random text under a series of register settings, extremes first;
        // a setting may land in the middle of a string, restarting the pen
        for (setting = 0; setting < SETTING_COUNT; setting++)
        begin
            max_len = 10;
            case (setting)
                0: apply_setting(15'h4000, 15'h3FFF, 8'd1, 16'h0000);
                1:
                begin
                    // long strings at full scale run the pen into saturation
                    apply_setting(15'h3FFF, 15'h4000, 8'd255, 16'hFFFF);
                    max_len = 40;
                end
                2: apply_setting(15'($urandom()), 15'($urandom()), 8'd0, 16'($urandom()));
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        scale = 8'($urandom_range(1, 255));
                    else
                        scale = 8'($urandom_range(1, 6));
                    apply_setting(15'($urandom()), 15'($urandom()), scale, 16'($urandom()));
                end
            endcase
            stop_at = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < stop_at)
                send_phrase(max_len);
            wait_until_drawn();
        end

        $display("covered %0d text bytes in %0d strings under %0d register settings",
                 bytes_sent, strings_sent, settings_applied + 1);
        $display("compared %0d rectangles, %0d field mismatches", rects_checked, mismatch_count);
        if (mismatch_count == 0 && rects_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ttrg_pkg.sv
hw/rtl/ttrg_cfg.sv
hw/rtl/ttrg_ctrl.sv
hw/rtl/ttrg_datapath.sv
hw/rtl/text_to_rectangle_generator.sv
dv/ttrg_rect_checker.sv
dv/tb_text_to_rectangle_generator.sv
